### rtl/cie_pkg.sv
// ============================================================================
// cie_pkg
// Shared types and constants for the identifier extractor that skips
// comments and literals.
// ============================================================================
package cie_pkg;

    // Longest word plus one; a word holds at most MAX_WORD_LEN-1 letters.
    localparam int MAX_WORD_LEN = 64;
    localparam int WLEN_W       = 7;

    // Characters that steer the lexer.
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Output queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_CHAR   = 3'd1,
        MODE_STRING = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4,
        MODE_STAR   = 3'd5,
        MODE_WORD   = 3'd6
    } t_lex_mode;

    typedef enum logic [1:0] {
        KIND_TEXT     = 2'd0,
        KIND_WORDCH   = 2'd1,
        KIND_ENDWORD  = 2'd2,
        KIND_ENDINPUT = 2'd3
    } t_kind;

    typedef struct packed {
        t_lex_mode         mode;
        logic              slash;
        logic [WLEN_W-1:0] wlen;
    } t_lex_state;

    // One result beat as it leaves the block.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] out_byte;
        logic       last;
    } t_beat;

    // All results caused by one input beat.
    typedef struct packed {
        t_beat r0;
        t_beat r1;
        logic  two;
    } t_step_out;

endpackage

### rtl/cie_if.sv
// ============================================================================
// cie_in_if / cie_out_if
// Valid/ready channels carrying source bytes in and lexer results out.
// ============================================================================
interface cie_in_if;
    import cie_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cie_out_if;
    import cie_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

### rtl/c_identifier_extractor_skipping_comments_core.sv
// ============================================================================
// c_identifier_extractor_skipping_comments_core
// Lexer that passes C source bytes through, marking letter runs in normal
// text as words and leaving literals and comments whole.
// ============================================================================
// Results are registered in the result queue before they are offered.
// Throughput: one input beat per cycle while the four-entry result queue has
// room for two; beats that give two results drain at one result per cycle while o_out.ready is high.
// Reset (i_rst_n low, synchronous): mode returns to normal text, slash flag
// and word length clear, and the result queue empties.
module c_identifier_extractor_skipping_comments_core
    import cie_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    cie_in_if.sink    i_in,
    cie_out_if.source o_out
);

    t_lex_state r_state;
    t_lex_state n_state;
    t_step_out  step_res;
    t_beat      head;
    logic       room;
    logic       accept;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Combinational lexer step on the current mode and the offered byte.
    cie_lex_step u_step (
        .i_state (r_state),
        .i_byte  (i_in.in_byte),
        .i_eoi   (i_in.end_of_input),
        .o_state (n_state),
        .o_res   (step_res)
    );

    // Lexer state advances on every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{mode: MODE_NORMAL, slash: 1'b0, wlen: '0};
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Results wait in a short queue so input keeps flowing under output stall.
    cie_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (step_res),
        .i_pop   (o_out.ready),
        .o_room  (room),
        .o_valid (o_out.valid),
        .o_beat  (head)
    );

    assign o_out.kind     = head.kind;
    assign o_out.out_byte = head.out_byte;
    assign o_out.last     = head.last;

endmodule

### rtl/cie_lex_step.sv
// ============================================================================
// cie_lex_step
// Next-state and result logic of the lexer for one input beat.
// ============================================================================
module cie_lex_step
    import cie_pkg::*;
(
    input  t_lex_state i_state,
    input  logic [7:0] i_byte,
    input  logic       i_eoi,
    output t_lex_state o_state,
    output t_step_out  o_res
);

    logic              is_letter;
    logic [WLEN_W-1:0] wlen_inc;
    logic [WLEN_W-1:0] wlen_start;
    t_beat             text_beat;
    t_beat             word_beat;
    t_beat             endw_beat;
    t_beat             endi_beat;

    assign is_letter  = ((i_byte >= 8'h41) && (i_byte <= 8'h5A)) ||
                        ((i_byte >= 8'h61) && (i_byte <= 8'h7A));
    assign wlen_inc   = i_state.wlen + WLEN_W'(1);
    assign wlen_start = WLEN_W'(1);

    assign text_beat = '{kind: KIND_TEXT,     out_byte: i_byte, last: 1'b0};
    assign word_beat = '{kind: KIND_WORDCH,   out_byte: i_byte, last: 1'b0};
    assign endw_beat = '{kind: KIND_ENDWORD,  out_byte: 8'h00,  last: 1'b0};
    assign endi_beat = '{kind: KIND_ENDINPUT, out_byte: 8'h00,  last: 1'b0};

    // Mode transitions and the one or two results of this beat.
    always_comb begin
        o_state = i_state;
        o_res   = '{r0: text_beat, r1: endw_beat, two: 1'b0};

        if (i_eoi) begin
            o_state = '{mode: MODE_NORMAL, slash: 1'b0, wlen: '0};
            if (i_state.mode == MODE_WORD) begin
                o_res.r0  = endw_beat;
                o_res.r1  = endi_beat;
                o_res.two = 1'b1;
            end else begin
                o_res.r0 = endi_beat;
            end
        end else begin
            case (i_state.mode)
                MODE_WORD: begin
                    if (is_letter) begin
                        // Letter continues the word; close it at the length limit.
                        o_res.r0 = word_beat;
                        if (wlen_inc >= WLEN_W'(MAX_WORD_LEN - 1)) begin
                            o_res.two     = 1'b1;
                            o_state.wlen  = '0;
                            o_state.mode  = MODE_NORMAL;
                        end else begin
                            o_state.wlen  = wlen_inc;
                        end
                    end else begin
                        // End of word, then the byte as normal text; a slash byte leaves a slash pending.
                        o_res.r0      = endw_beat;
                        o_res.r1      = text_beat;
                        o_res.two     = 1'b1;
                        o_state.wlen  = '0;
                        o_state.slash = (i_byte == CH_SLASH);
                        if (i_byte == CH_QUOTE) begin
                            o_state.mode = MODE_CHAR;
                        end else if (i_byte == CH_DQUOTE) begin
                            o_state.mode = MODE_STRING;
                        end else begin
                            o_state.mode = MODE_NORMAL;
                        end
                        if ((i_byte == CH_QUOTE) || (i_byte == CH_DQUOTE)) begin
                            o_state.slash = 1'b0;
                        end
                    end
                end
                MODE_CHAR: begin
                    if (i_byte == CH_QUOTE) begin
                        o_state.mode  = MODE_NORMAL;
                        o_state.slash = 1'b0;
                    end
                end
                MODE_STRING: begin
                    if (i_byte == CH_DQUOTE) begin
                        o_state.mode  = MODE_NORMAL;
                        o_state.slash = 1'b0;
                    end
                end
                MODE_LINE: begin
                    if (i_byte == CH_NEWLINE) begin
                        o_state.mode  = MODE_NORMAL;
                        o_state.slash = 1'b0;
                    end
                end
                MODE_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        o_state.mode = MODE_STAR;
                    end
                end
                MODE_STAR: begin
                    if (i_byte == CH_SLASH) begin
                        o_state.mode  = MODE_NORMAL;
                        o_state.slash = 1'b0;
                    end else if (i_byte != CH_STAR) begin
                        o_state.mode = MODE_BLOCK;
                    end
                end
                default: begin
                    // Normal text, and the unused mode code treated the same way.
                    o_state.mode = MODE_NORMAL;
                    if (is_letter) begin
                        o_res.r0      = word_beat;
                        o_state.slash = 1'b0;
                        if (wlen_start >= WLEN_W'(MAX_WORD_LEN - 1)) begin
                            o_res.two    = 1'b1;
                            o_state.wlen = '0;
                        end else begin
                            o_state.wlen = wlen_start;
                            o_state.mode = MODE_WORD;
                        end
                    end else if (i_byte == CH_QUOTE) begin
                        o_state.mode  = MODE_CHAR;
                        o_state.slash = 1'b0;
                    end else if (i_byte == CH_DQUOTE) begin
                        o_state.mode  = MODE_STRING;
                        o_state.slash = 1'b0;
                    end else if (i_state.slash && (i_byte == CH_SLASH)) begin
                        o_state.mode  = MODE_LINE;
                        o_state.slash = 1'b0;
                    end else if (i_state.slash && (i_byte == CH_STAR)) begin
                        o_state.mode  = MODE_BLOCK;
                        o_state.slash = 1'b0;
                    end else begin
                        o_state.slash = (i_byte == CH_SLASH);
                    end
                end
            endcase
        end

        // Mark the final result of this beat.
        if (o_res.two) begin
            o_res.r1.last = 1'b1;
        end else begin
            o_res.r0.last = 1'b1;
        end
    end

endmodule

### rtl/cie_out_fifo.sv
// ============================================================================
// cie_out_fifo
// Small result queue that takes one or two beats per cycle and gives one.
// ============================================================================
module cie_out_fifo
    import cie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_step_out  i_data,
    input  logic       i_pop,
    output logic       o_room,
    output logic       o_valid,
    output t_beat      o_beat
);

    t_beat                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_count;
    logic [FIFO_AW-1:0]   n_wr;
    logic [FIFO_AW-1:0]   n_rd;
    logic [FIFO_CW-1:0]   n_count;
    logic [FIFO_CW-1:0]   push_n;
    logic                 pop_ok;

    // Room for a full two-beat push; output side is the head entry.
    assign o_room  = (r_count <= FIFO_CW'(FIFO_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_beat  = r_mem[r_rd];
    assign pop_ok  = i_pop && o_valid;
    assign push_n  = i_push ? (i_data.two ? FIFO_CW'(2) : FIFO_CW'(1)) : '0;

    // Pointer and fill count update.
    always_comb begin
        n_wr    = r_wr + push_n[FIFO_AW-1:0];
        n_rd    = r_rd + FIFO_AW'(pop_ok);
        n_count = r_count + push_n - FIFO_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Entry storage, written at the tail and the slot after it.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data.r0;
            if (i_data.two) begin
                r_mem[r_wr + FIFO_AW'(1)] <= i_data.r1;
            end
        end
    end

endmodule
